// ----- rtl/core/srfc_pkg.sv -----
// Shared types, constants and CRC function of the sensor reply frame checker.
`default_nettype none
package srfc_pkg;

   // Modbus CRC-16 parameters
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'hA001;

   // Expected header bytes
   localparam logic [7:0]  FUNC_CODE = 8'h03;
   localparam logic [7:0]  REG_COUNT = 8'h04;

   // Temperature sign-magnitude fields
   localparam logic [15:0] SIGN_BIT  = 16'h8000;
   localparam logic [15:0] MAG_MASK  = 16'h7FFF;

   // Byte position within a reply
   typedef logic [2:0] pos_type;
   localparam pos_type BYTE_FUNC    = 3'd0;
   localparam pos_type BYTE_COUNT   = 3'd1;
   localparam pos_type BYTE_HUM_HI  = 3'd2;
   localparam pos_type BYTE_HUM_LO  = 3'd3;
   localparam pos_type BYTE_TEMP_HI = 3'd4;
   localparam pos_type BYTE_TEMP_LO = 3'd5;
   localparam pos_type BYTE_CRC_LO  = 3'd6;
   localparam pos_type BYTE_CRC_HI  = 3'd7;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_FUNC  = 2'd1,
      STATUS_BAD_COUNT = 2'd2,
      STATUS_BAD_CRC   = 2'd3
   } status_type;

   // Result payload widths
   localparam int RSP_DATA_W = 40;

   // One byte through the reflected CRC, low bit first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
      logic [15:0] crc;
      crc = crc_in ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sensor_reply_frame_checker_core.sv -----
// Path: a byte is held in the input register; the result of byte 7 is loaded
// into the result register when that byte leaves the input register.
// Throughput: one byte per cycle; the input stage stalls only while a
// finished result waits in the result register and the next byte is byte 7.
// Reset (synchronous, active high) empties both registers, sets the byte
// count to 0, the CRC to 0xFFFF and clears the header error.
`default_nettype none
module sensor_reply_frame_checker_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,  // [7:0] data_byte
   input  wire logic                            req_tuser,  // [0] frame_start
   // result channel
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [1:0] status, [17:2] temperature_tenths, [33:18] humidity_tenths, [39:34] zero
   output logic [srfc_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import srfc_pkg::*;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_start_ff;

   // frame state
   pos_type     pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [1:0]  herr_ff, herr_in;
   logic [15:0] hum_ff, hum_in;
   logic [15:0] temp_ff, temp_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   pos_type     pos;
   logic        out_free;
   logic        advance;
   logic        last_byte;
   logic [15:0] crc_base;
   logic [1:0]  herr_base;
   logic [15:0] got_crc;
   status_type  status;
   logic [15:0] mag;
   logic [15:0] temp_res;
   logic [15:0] hum_res;

   // handshake
   assign pos       = in_start_ff ? BYTE_FUNC : pos_ff;
   assign last_byte = (pos == BYTE_CRC_HI);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign advance   = in_valid_ff && (!last_byte || out_free);
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   // per-byte frame update
   assign crc_base  = (pos == BYTE_FUNC) ? CRC_INIT : crc_ff;
   assign herr_base = (pos == BYTE_FUNC) ? 2'd0 : herr_ff;
   assign got_crc   = {in_byte_ff, crc_lo_ff};

   always_comb begin
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      herr_in   = herr_ff;
      hum_in    = hum_ff;
      temp_in   = temp_ff;
      crc_lo_in = crc_lo_ff;
      if (advance) begin
         pos_in    = pos + 3'd1;
         herr_in   = herr_base;
         crc_in    = (pos < BYTE_CRC_LO) ? crc_feed(crc_base, in_byte_ff) : crc_base;
         case (pos)
            BYTE_FUNC: begin
               if (in_byte_ff != FUNC_CODE) herr_in = STATUS_BAD_FUNC;
            end
            BYTE_COUNT: begin
               if (herr_base == STATUS_OK && in_byte_ff != REG_COUNT) begin
                  herr_in = STATUS_BAD_COUNT;
               end
            end
            BYTE_HUM_HI:  hum_in    = {in_byte_ff, hum_ff[7:0]};
            BYTE_HUM_LO:  hum_in    = {hum_ff[15:8], in_byte_ff};
            BYTE_TEMP_HI: temp_in   = {in_byte_ff, temp_ff[7:0]};
            BYTE_TEMP_LO: temp_in   = {temp_ff[15:8], in_byte_ff};
            BYTE_CRC_LO:  crc_lo_in = in_byte_ff;
            default: ;
         endcase
      end
   end

   // result for byte 7: header fault first, then checksum
   always_comb begin
      if (herr_ff != STATUS_OK) begin
         status = status_type'(herr_ff);
      end else if (got_crc != crc_ff) begin
         status = STATUS_BAD_CRC;
      end else begin
         status = STATUS_OK;
      end
      mag = temp_ff & MAG_MASK;
      if (status == STATUS_OK) begin
         temp_res = ((temp_ff & SIGN_BIT) != 16'd0) ? (16'd0 - mag) : mag;
         hum_res  = hum_ff;
      end else begin
         temp_res = 16'd0;
         hum_res  = 16'd0;
      end
   end

   // result register load and drain
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (advance && last_byte) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, hum_res, temp_res, status};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pos_ff       <= BYTE_FUNC;
         crc_ff       <= CRC_INIT;
         herr_ff      <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         herr_ff      <= herr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
      hum_ff      <= hum_in;
      temp_ff     <= temp_in;
      crc_lo_ff   <= crc_lo_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ----- rtl/core/srfc_checker.sv -----
// Port-level assertions of the sensor reply frame checker and their bind.
`default_nettype none
module srfc_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_tvalid,
   input wire logic                        req_tready,
   input wire logic [7:0]                  req_tdata,
   input wire logic                        req_tuser,
   input wire logic                        rsp_tvalid,
   input wire logic                        rsp_tready,
   input wire logic [srfc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import srfc_pkg::*;

   // a result held under backpressure keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // reset empties the result register
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a failed frame carries no readings
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != STATUS_OK |-> rsp_tdata[33:2] == 32'd0)
      else $error("failed frame with nonzero readings");

   // sign-magnitude conversion never yields the most negative code, and the pad bits stay zero
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[17:2] != 16'h8000 && rsp_tdata[39:34] == 6'd0)
      else $error("temperature out of range or padding set");

endmodule

bind sensor_reply_frame_checker_core srfc_checker u_srfc_checker (.*);
`default_nettype wire

// ----- tb/srfc_reading_checker.sv -----
// Predicts sensor readings from the request stream and compares each rsp against them.
`default_nettype none
module srfc_reading_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   input  wire logic                                 req_tready,
   input  wire logic [7:0]                           req_tdata,
   input  wire logic                                 req_tuser,
   input  wire logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire logic [srfc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output int                                        mismatches,
   output int                                        readings_due
);
   timeunit 1ns;
   timeprecision 1ps;

   import srfc_pkg::*;

   typedef struct packed {
      status_type  status;
      logic [15:0] temp;
      logic [15:0] hum;
   } reading_type;

   // readings owed by the block, oldest first
   reading_type pending_readings[$];

   // shadow of the frame decoder
   pos_type     frame_pos;
   logic [15:0] crc_acc;
   logic [15:0] hum_word;
   logic [15:0] temp_word;
   status_type  hdr_fault;
   logic [7:0]  crc_lo_byte;

   // reflected CRC-16, one bit per pass, LSB first
   function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      r = acc ^ {8'h00, b};
      repeat (8) begin
         r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY) : {1'b0, r[15:1]};
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [39:0] got,
                                input logic [39:0] want);
      if (mismatches < 40) begin
         $display("%0t ns: reading mismatch on %s: got %h want %h", $time, what, got, want);
      end
      mismatches++;
   endtask

   // advance the frame decoder by one request, queue a reading after the CRC high byte
   task automatic absorb_byte(input logic [7:0] b, input logic first);
      pos_type     p;
      logic [15:0] got_crc;
      logic [15:0] mag;
      reading_type r;
      p = first ? BYTE_FUNC : frame_pos;
      if (p == BYTE_FUNC) begin
         crc_acc   = CRC_INIT;
         hdr_fault = STATUS_OK;
      end
      if (p < BYTE_CRC_LO) begin
         crc_acc = modbus_crc_step(crc_acc, b);
      end
      case (p)
         BYTE_FUNC: begin
            if (b != FUNC_CODE) hdr_fault = STATUS_BAD_FUNC;
         end
         BYTE_COUNT: begin
            // count is only judged when the function code passed
            if (hdr_fault == STATUS_OK && b != REG_COUNT) hdr_fault = STATUS_BAD_COUNT;
         end
         BYTE_HUM_HI:  hum_word[15:8]  = b;
         BYTE_HUM_LO:  hum_word[7:0]   = b;
         BYTE_TEMP_HI: temp_word[15:8] = b;
         BYTE_TEMP_LO: temp_word[7:0]  = b;
         BYTE_CRC_LO:  crc_lo_byte     = b;
         default: begin
            got_crc = {b, crc_lo_byte};
            r = '0;
            if (hdr_fault != STATUS_OK) begin
               r.status = hdr_fault;
            end else if (got_crc != crc_acc) begin
               r.status = STATUS_BAD_CRC;
            end else begin
               // sign-magnitude to two's complement; 0x8000 folds to zero
               r.status = STATUS_OK;
               mag      = temp_word & MAG_MASK;
               r.temp   = (temp_word & SIGN_BIT) != 16'h0000 ? 16'h0000 - mag : mag;
               r.hum    = hum_word;
            end
            pending_readings.push_back(r);
         end
      endcase
      frame_pos = p + 3'd1;
   endtask

   task automatic check_reading(input logic [RSP_DATA_W-1:0] d);
      reading_type want;
      if (pending_readings.size() == 0) begin
         flag_mismatch("unexpected reading", 40'(d), 40'h0);
         return;
      end
      want = pending_readings.pop_front();
      if (d[1:0] != want.status) flag_mismatch("status", 40'(d[1:0]), 40'(want.status));
      if (d[17:2] != want.temp) flag_mismatch("temperature", 40'(d[17:2]), 40'(want.temp));
      if (d[33:18] != want.hum) flag_mismatch("humidity", 40'(d[33:18]), 40'(want.hum));
      if (d[RSP_DATA_W-1:34] != '0) flag_mismatch("pad bits", 40'(d[RSP_DATA_W-1:34]), 40'h0);
   endtask

   // rsp side first so a stray reading is never hidden by a fresh expectation
   always @(posedge clock) begin
      if (reset) begin
         frame_pos   = BYTE_FUNC;
         crc_acc     = CRC_INIT;
         hum_word    = '0;
         temp_word   = '0;
         hdr_fault   = STATUS_OK;
         crc_lo_byte = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_reading(rsp_tdata);
         if (req_tvalid && req_tready) absorb_byte(req_tdata, req_tuser);
      end
      readings_due <= pending_readings.size();
   end

endmodule
`default_nettype wire

// ----- tb/tb_sensor_reply_frame_checker_core.sv -----
// Stimulus, flow control and verdict for the sensor reply frame checker core.
`default_nettype none
module tb_sensor_reply_frame_checker_core;
   timeunit 1ns;
   timeprecision 1ps;

   import srfc_pkg::*;

   localparam int RANDOM_ITEMS = 1050;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int   mismatches;
   int   readings_due;
   int   gap_pct = 29;
   int   stall_pct = 60;
   int   quiet_cycles = 0;
   int   bytes_sent = 0;
   logic frame_aligned = 1'b0;

   sensor_reply_frame_checker_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   srfc_reading_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .mismatches   (mismatches),
      .readings_due (readings_due)
   );

   always #4 clock = ~clock;

   // random backpressure on the result side
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // watchdog: too long without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one request, with random idle cycles ahead of it
   task automatic send_req(input logic [7:0] b, input logic first);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // full eight-byte reply; crc_flip corrupts the trailing checksum
   task automatic send_frame(input logic [7:0] func, input logic [7:0] count,
                             input logic [15:0] hum, input logic [15:0] temp,
                             input logic marked, input logic [15:0] crc_flip);
      logic [7:0]  frame_bytes [8];
      logic [15:0] crc;
      frame_bytes[0] = func;
      frame_bytes[1] = count;
      frame_bytes[2] = hum[15:8];
      frame_bytes[3] = hum[7:0];
      frame_bytes[4] = temp[15:8];
      frame_bytes[5] = temp[7:0];
      crc = CRC_INIT;
      for (int i = 0; i < 6; i++) crc = crc_feed(crc, frame_bytes[i]);
      crc = crc ^ crc_flip;
      frame_bytes[6] = crc[7:0];
      frame_bytes[7] = crc[15:8];
      for (int i = 0; i < 8; i++) send_req(frame_bytes[i], marked && (i == 0));
      frame_aligned = 1'b1;
   endtask

   // data words lean toward the sign and range corners
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'h7FFF;
         2: return 16'h8000;
         3: return 16'hFFFF;
         4: return 16'h8000 | 16'($urandom_range(0, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_reply();
      int          kind;
      int          n;
      logic [7:0]  func;
      logic [7:0]  count;
      logic [15:0] flip;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         // well-formed reply, occasionally with a bad header or checksum
         func  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : FUNC_CODE;
         count = ($urandom_range(0, 9) == 0) ? 8'($urandom) : REG_COUNT;
         flip  = ($urandom_range(0, 6) == 0) ? 16'h0001 << $urandom_range(0, 15) : 16'h0000;
         send_frame(func, count, pick_word(), pick_word(),
                    !frame_aligned || ($urandom_range(0, 3) != 0), flip);
      end else if (kind < 85) begin
         // truncated reply, cut off by the next frame start
         n = $urandom_range(1, 7);
         send_req(($urandom_range(0, 1) == 0) ? FUNC_CODE : 8'($urandom), 1'b1);
         for (int i = 1; i < n; i++) send_req(8'($urandom), 1'b0);
         frame_aligned = 1'b0;
      end else begin
         // line noise with stray frame starts
         n = $urandom_range(1, 12);
         for (int i = 0; i < n; i++) send_req(8'($urandom), $urandom_range(0, 7) == 0);
         frame_aligned = 1'b0;
      end
   endtask

   initial begin
      int random_end;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: good reply with negative zero, unmarked follow-on reply with
      // both header faults, a dropped partial frame, bad count over bad checksum
      send_frame(FUNC_CODE, REG_COUNT, 16'hFFFF, 16'h8000, 1'b1, 16'h0000);
      send_frame(8'h00, 8'hFF, 16'h0000, 16'h7FFF, 1'b0, 16'h0000);
      send_req(FUNC_CODE, 1'b1);
      send_frame(FUNC_CODE, 8'h05, 16'h1234, 16'hFFFF, 1'b1, 16'h8000);

      // random: three flow-control phases by request count
      random_end = bytes_sent + RANDOM_ITEMS;
      while (bytes_sent < random_end) begin
         if (bytes_sent < random_end - 2 * RANDOM_ITEMS / 3) begin
            gap_pct   = 29;
            stall_pct = 60;
         end else if (bytes_sent < random_end - RANDOM_ITEMS / 3) begin
            gap_pct   = 60;
            stall_pct = 29;
         end else begin
            gap_pct   = 0;
            stall_pct = 0;
         end
         random_reply();
      end
      req_tvalid <= 1'b0;

      // drain outstanding readings, then give the pipeline time to misbehave
      @(posedge clock);
      while (readings_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire
